/* design/ps2_scancode_prefix_parser_macros.svh */
// Assertion macros shared by the PS/2 scancode parser RTL.
// No dependencies; include with the bare file name.
`ifndef PS2_SCANCODE_PREFIX_PARSER_MACROS_SVH
`define PS2_SCANCODE_PREFIX_PARSER_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define PS2SP_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define PS2SP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* design/ps2sp_pkg.sv */
// Types and byte codes for the PS/2 scan set 2 prefix parser.
// No dependencies; imported by ps2sp_step and the top level.
`default_nettype none

package ps2sp_pkg;

  localparam logic [7:0] BYTE_ACK      = 8'hFA;
  localparam logic [7:0] BYTE_RESEND   = 8'hFE;
  localparam logic [7:0] BYTE_ECHO     = 8'hEE;
  localparam logic [7:0] BYTE_BAT_OK   = 8'hAA;
  localparam logic [7:0] BYTE_EXTEND   = 8'hE0;
  localparam logic [7:0] BYTE_BREAK    = 8'hF0;
  localparam logic [7:0] BYTE_PAUSE    = 8'hE1;
  localparam logic [7:0] BYTE_FAKESHFT = 8'h12;
  localparam logic [2:0] PAUSE_SKIP    = 3'd7;

  // Held pair after reset or a release of the held key: E0 00 matches no key.
  localparam logic [7:0] HELD_CODE_IDLE = 8'h00;
  localparam logic       HELD_EXT_IDLE  = 1'b1;

  typedef struct packed {
    logic [2:0] skip_left;
    logic       ext_pending;
    logic       release_pending;
    logic [7:0] held_code;
    logic       held_ext;
  } state_t;

  typedef struct packed {
    logic [7:0] key_code;
    logic       is_extended;
    logic       is_release;
  } event_t;

endpackage

`default_nettype wire

/* design/ps2sp_step.sv */
// Per-byte decode: next parser state and the optional key event.
// Depends on ps2sp_pkg.
`default_nettype none

module ps2sp_step
  import ps2sp_pkg::*;
(
  input  logic [7:0] scan_byte,
  input  state_t     st,
  output state_t     st_nxt,
  output logic       emit,
  output event_t     evt
);

  logic is_reply;
  logic held_match;

  assign is_reply   = (scan_byte == BYTE_ACK) || (scan_byte == BYTE_RESEND) ||
                      (scan_byte == BYTE_ECHO) || (scan_byte == BYTE_BAT_OK);
  assign held_match = (scan_byte == st.held_code) && (st.ext_pending == st.held_ext);

  assign evt.key_code    = scan_byte;
  assign evt.is_extended = st.ext_pending;
  assign evt.is_release  = st.release_pending;

  always_comb begin
    st_nxt = st;
    emit   = 1'b0;
    priority if (st.skip_left != 3'd0) begin
      st_nxt.skip_left = st.skip_left - 3'd1;
    end else if (is_reply) begin
      // drop
    end else if (scan_byte == BYTE_EXTEND) begin
      st_nxt.ext_pending = 1'b1;
    end else if (scan_byte == BYTE_BREAK) begin
      st_nxt.release_pending = 1'b1;
    end else if (scan_byte == BYTE_PAUSE) begin
      st_nxt.skip_left = PAUSE_SKIP;
    end else if (held_match && !st.release_pending) begin
      // typematic repeat: drop and clear marks
      st_nxt.ext_pending     = 1'b0;
      st_nxt.release_pending = 1'b0;
    end else begin
      if (!st.release_pending) begin
        st_nxt.held_code = scan_byte;
        st_nxt.held_ext  = st.ext_pending;
      end else if (held_match) begin
        st_nxt.held_code = HELD_CODE_IDLE;
        st_nxt.held_ext  = HELD_EXT_IDLE;
      end
      st_nxt.ext_pending     = 1'b0;
      st_nxt.release_pending = 1'b0;
      emit = !((scan_byte == BYTE_FAKESHFT) && st.ext_pending);
    end
  end

endmodule

`default_nettype wire

/* design/ps2_scancode_prefix_parser.sv */
// PS/2 scan set 2 prefix parser. Takes one received keyboard byte per
// request and turns the stream into key events (code, extended, release).
// Reply bytes FA, FE, EE and AA are dropped; E0 and F0 set extended and
// release marks; E1 swallows the rest of the pause sequence (seven bytes);
// a repeated press of the last pressed key is suppressed and clears the
// marks; the fake shift E0 12 never produces an event. Throughput is one
// byte per cycle while the consumer keeps up: the byte is captured in an
// input register, decoded by a single short compare network, and the
// event lands in an output register that drives out_valid. Both registers
// advance together whenever the output register is empty or being drained,
// so a stalled consumer holds back at most one byte in flight. Parser state
// is updated only when the captured byte advances. No clearing pass after
// reset: the block is ready as soon as reset is released.
// Depends on ps2sp_pkg, ps2sp_step and the macros header.
`default_nettype none

`include "ps2_scancode_prefix_parser_macros.svh"

module ps2_scancode_prefix_parser
  import ps2sp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_scan_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_key_code,
  output logic       out_is_extended,
  output logic       out_is_release
);

  // input register
  logic       s1_vld_r;
  logic [7:0] s1_byte_r;

  // parser state
  state_t st_r;
  state_t st_nxt;

  // output register
  logic   out_vld_r;
  event_t out_evt_r;

  logic   emit;
  event_t evt;
  logic   s1_adv;

  ps2sp_step u_step (
    .scan_byte (s1_byte_r),
    .st        (st_r),
    .st_nxt    (st_nxt),
    .emit      (emit),
    .evt       (evt)
  );

  // Advance the captured byte when the output slot is free or draining.
  assign s1_adv   = !out_vld_r || out_ready;
  assign in_ready = !s1_vld_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_scan_byte;
    end
  end

  // Commit the parser state only when the byte is consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.skip_left       <= 3'd0;
      st_r.ext_pending     <= 1'b0;
      st_r.release_pending <= 1'b0;
      st_r.held_code       <= HELD_CODE_IDLE;
      st_r.held_ext        <= HELD_EXT_IDLE;
    end else if (s1_vld_r && s1_adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= s1_vld_r && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_vld_r && emit) begin
      out_evt_r <= evt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_key_code    = out_evt_r.key_code;
  assign out_is_extended = out_evt_r.is_extended;
  assign out_is_release  = out_evt_r.is_release;

  // A byte consumed during the pause skip never yields an event.
  `PS2SP_ASSERT_NEXT(a_skip_no_event, clk, rst_n,
    s1_vld_r && s1_adv && (st_r.skip_left != 3'd0), !out_vld_r)
  // An emitted event leaves both marks clear.
  `PS2SP_ASSERT_NEXT(a_marks_cleared, clk, rst_n,
    s1_vld_r && s1_adv && emit, !st_r.ext_pending && !st_r.release_pending)
  // Prefix bytes and the fake shift never reach the output.
  `PS2SP_ASSERT_SAME(a_no_prefix_out, clk, rst_n, out_vld_r,
    (out_evt_r.key_code != BYTE_EXTEND) && (out_evt_r.key_code != BYTE_BREAK) &&
    (out_evt_r.key_code != BYTE_PAUSE) &&
    !(out_evt_r.is_extended && (out_evt_r.key_code == BYTE_FAKESHFT)))

endmodule

`default_nettype wire
